// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check, sampled on the rising edge, masked while reset is active.
`define ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// Concurrent check without reset masking.
`define ASSERT_ALW(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ===== rtl/mpa_pkg.sv =====
`timescale 1ns / 1ps
package mpa_pkg;

	localparam int OBS_COUNT   = 4;
	localparam int MAX_HIDDEN  = 64;
	localparam int MAX_OUTPUTS = 8;
	localparam int PARAM_DEPTH = 1024;
	localparam int FRAC_BITS   = 16;
	localparam int TANH_LIMIT  = 256;
	localparam int DIV_STEPS   = 32 + FRAC_BITS;

	localparam logic [63:0] EXP_STEP_FRAC = 64'd277001592;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_ACT   = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_MODEL_LOADED = 2'd0;
	localparam logic [1:0] CFG_HIDDEN_COUNT = 2'd1;
	localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd2;

	localparam logic [2:0] ACTION_COAST = 3'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SC_RD,
		S_SC_GO,
		S_SC_WAIT,
		S_B_RD,
		S_B_LD,
		S_W_RD,
		S_W_MUL,
		S_W_ACC,
		S_POST,
		S_DONE
	} mpa_state_t;

	typedef struct packed {
		logic       cap;
		logic       wr_param;
		logic [9:0] rd_addr;
		logic [5:0] h_rd_addr;
		logic       div_start;
		logic [1:0] obs_idx;
		logic       acc_load;
		logic       mul_en;
		logic       acc_en;
		logic       layer2;
		logic       h_wr;
		logic [5:0] n_idx;
		logic       arg_upd;
		logic       arg_first;
		logic       out_load;
		logic       out_coast;
	} mpa_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_full;
	} mpa_status_t;

	typedef logic [16:0] tanh_tab_t [0:TANH_LIMIT];

	// tanh magnitude table in Q16, built at elaboration
	function automatic tanh_tab_t build_tanh_tab();
		tanh_tab_t   tab;
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] q;
		int          n;
		int          b;
		e = 64'h1_0000_0000;
		for (n = 0; n <= TANH_LIMIT; n++) begin
			d   = e + 64'h1_0000_0000;
			num = (64'd1 << 49) + (d >> 1);
			rem = '0;
			q   = '0;
			for (b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= d) begin
					rem  = rem - d;
					q[b] = 1'b1;
				end
			end
			tab[n] = 17'(64'd65536 - q);
			e = e + (e >> 32) * EXP_STEP_FRAC + (((e & 64'hFFFF_FFFF) * EXP_STEP_FRAC) >> 32);
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

// ===== rtl/mpa_div.sv =====
`timescale 1ns / 1ps
module mpa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	import mpa_pkg::*;

	logic        busy_q;
	logic        fin_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [47:0] num_q;
	logic        neg_q;
	logic [31:0] quo_q;
	logic [31:0] mag_x;
	logic [31:0] mag_s;
	logic [32:0] r2;
	logic [32:0] diff;
	logic        ge;

	assign mag_x = dividend[31] ? (32'd0 - dividend) : dividend;
	assign mag_s = divisor[31] ? (32'd0 - divisor) : divisor;
	assign r2    = {rem_q, num_q[47]};
	assign diff  = r2 - {1'b0, den_q};
	assign ge    = (r2 >= {1'b0, den_q});

	// control: start, count steps, pulse done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= 1'b0;
			done_q <= fin_q;
			if (start) begin
				if (divisor == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	// datapath: restoring division one bit a cycle, then sign and saturate; a zero divisor skips the loop
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= {mag_x, 16'b0};
			den_q <= mag_s;
			neg_q <= dividend[31] ^ divisor[31];
			if (divisor == '0) begin
				if (dividend[31])
					quo_q <= 32'h8000_0000;
				else if (dividend != '0)
					quo_q <= 32'h7FFF_FFFF;
				else
					quo_q <= '0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : r2[31:0];
			num_q <= {num_q[46:0], ge};
		end else if (fin_q) begin
			if (!neg_q)
				quo_q <= (num_q[47:31] != '0) ? 32'h7FFF_FFFF : num_q[31:0];
			else
				quo_q <= (num_q > 48'h8000_0000) ? 32'h8000_0000 : (32'd0 - num_q[31:0]);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/mpa_datapath.sv =====
`timescale 1ns / 1ps
module mpa_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mpa_pkg::mpa_cmd_t   cmd,
	output mpa_pkg::mpa_status_t st,
	input  logic [9:0]          param_index,
	input  logic signed [31:0]  param_value,
	input  logic signed [31:0]  position,
	input  logic signed [31:0]  velocity_obs,
	input  logic signed [31:0]  angle,
	input  logic signed [31:0]  angular_rate,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [2:0]          action
);
	import mpa_pkg::*;

	logic [31:0]        param_mem [PARAM_DEPTH];
	logic [31:0]        hid_mem [MAX_HIDDEN];
	logic [31:0]        rdata_q;
	logic [31:0]        hdata_q;
	logic [31:0]        obs_q [OBS_COUNT];
	logic signed [63:0] prod_q;
	logic signed [31:0] acc_q;
	logic signed [31:0] best_val_q;
	logic [2:0]         best_q;
	logic               out_valid_q;
	logic [2:0]         action_q;
	logic               div_done;
	logic [31:0]        div_q;
	logic signed [31:0] mul_b;
	logic signed [48:0] sum;
	logic signed [31:0] sum_sat;
	logic signed [20:0] tk;
	logic [8:0]         tmag;
	logic [31:0]        tval;
	logic [31:0]        tanh_out;

	mpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (obs_q[cmd.obs_idx]),
		.divisor  (rdata_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// parameter memory: write on a write beat, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_param)
			param_mem[param_index] <= param_value;
		rdata_q <= param_mem[cmd.rd_addr];
	end

	// hidden activations: tanh of the finished sum
	always_ff @(posedge clk) begin
		if (cmd.h_wr)
			hid_mem[cmd.n_idx] <= tanh_out;
		hdata_q <= hid_mem[cmd.h_rd_addr];
	end

	// observations: capture raw, replace with scaled value
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			obs_q[0] <= position;
			obs_q[1] <= velocity_obs;
			obs_q[2] <= angle;
			obs_q[3] <= angular_rate;
		end else if (div_done) begin
			obs_q[cmd.obs_idx] <= div_q;
		end
	end

	// multiply, then floor-shift and saturating accumulate
	assign mul_b = cmd.layer2 ? hdata_q : obs_q[cmd.obs_idx];
	assign sum   = {{17{acc_q[31]}}, acc_q} + {prod_q[63], prod_q[63:FRAC_BITS]};
	always_comb begin
		if (sum > 49'sh0_7FFF_FFFF)
			sum_sat = 32'sh7FFF_FFFF;
		else if (sum < -49'sh0_8000_0000)
			sum_sat = 32'sh8000_0000;
		else
			sum_sat = sum[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= $signed(rdata_q) * mul_b;
		if (cmd.acc_load)
			acc_q <= rdata_q;
		else if (cmd.acc_en)
			acc_q <= sum_sat;
	end

	// tanh: step index, clamp, table lookup, restore sign
	assign tk = acc_q[31:FRAC_BITS-5];
	always_comb begin
		if (tk > 21'sd256)
			tmag = 9'd256;
		else if (tk < -21'sd256)
			tmag = 9'd256;
		else if (tk[20])
			tmag = 9'(-tk);
		else
			tmag = tk[8:0];
	end
	assign tval     = {15'b0, TANH_TAB[tmag]};
	assign tanh_out = tk[20] ? (32'd0 - tval) : tval;

	// argmax, first index wins ties
	always_ff @(posedge clk) begin
		if (cmd.arg_upd && (cmd.arg_first || acc_q > best_val_q)) begin
			best_val_q <= acc_q;
			best_q     <= cmd.n_idx[2:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			action_q <= cmd.out_coast ? ACTION_COAST : best_q;
	end

	assign st.div_done = div_done;
	assign st.out_full = out_valid_q;
	assign out_valid   = out_valid_q;
	assign action      = action_q;

endmodule

// ===== rtl/mpa_ctrl.sv =====
`timescale 1ns / 1ps
module mpa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [6:0]           cfg_data,
	input  logic                 out_ready,
	input  mpa_pkg::mpa_status_t st,
	output mpa_pkg::mpa_cmd_t    cmd
);
	import mpa_pkg::*;

	mpa_state_t state_q, state_d;
	logic        loaded_q;
	logic [6:0]  hcount_q;
	logic [3:0]  ocount_q;
	logic [5:0]  i_q;
	logic [5:0]  n_q;
	logic [9:0]  w_ptr_q;
	logic        layer2_q;
	logic        coast_q;
	logic [6:0]  h_eff;
	logic [3:0]  o_eff;
	logic [9:0]  b_b1;
	logic [9:0]  b_w2;
	logic [9:0]  b_b2;
	logic        accept;
	logic        i_last;
	logic        n_last;
	logic        slot_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			hcount_q <= 7'd16;
			ocount_q <= 4'd3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODEL_LOADED: loaded_q <= cfg_data[0];
				CFG_HIDDEN_COUNT: hcount_q <= cfg_data;
				CFG_OUTPUT_COUNT: ocount_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp counts and derive the parameter layout
	always_comb begin
		if (hcount_q == '0)
			h_eff = 7'd1;
		else if (hcount_q > 7'(MAX_HIDDEN))
			h_eff = 7'(MAX_HIDDEN);
		else
			h_eff = hcount_q;
		if (ocount_q == '0)
			o_eff = 4'd1;
		else if (ocount_q > 4'(MAX_OUTPUTS))
			o_eff = 4'(MAX_OUTPUTS);
		else
			o_eff = ocount_q;
	end
	assign b_b1 = 10'(OBS_COUNT) + {1'b0, h_eff, 2'b0};
	assign b_w2 = b_b1 + {3'b0, h_eff};
	assign b_b2 = b_w2 + ({3'b0, h_eff} * {6'b0, o_eff});

	assign accept    = in_valid && in_ready;
	assign i_last    = layer2_q ? ({1'b0, i_q} == h_eff - 7'd1) : (i_q == 6'(OBS_COUNT - 1));
	assign n_last    = layer2_q ? ({1'b0, n_q} == {3'b0, o_eff} - 7'd1)
	                            : ({1'b0, n_q} == h_eff - 7'd1);
	assign slot_free = !st.out_full || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (accept && operation == OP_ACT) state_d = loaded_q ? S_SC_RD : S_DONE;
			S_SC_RD:   state_d = S_SC_GO;
			S_SC_GO:   state_d = S_SC_WAIT;
			S_SC_WAIT: if (st.div_done) state_d = i_last ? S_B_RD : S_SC_RD;
			S_B_RD:    state_d = S_B_LD;
			S_B_LD:    state_d = S_W_RD;
			S_W_RD:    state_d = S_W_MUL;
			S_W_MUL:   state_d = S_W_ACC;
			S_W_ACC:   state_d = i_last ? S_POST : S_W_RD;
			S_POST:    state_d = (n_last && layer2_q) ? S_DONE : S_B_RD;
			S_DONE:    if (slot_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		cmd.cap       = accept && operation == OP_ACT;
		cmd.wr_param  = accept && operation == OP_WRITE;
		cmd.h_rd_addr = i_q;
		cmd.obs_idx   = i_q[1:0];
		cmd.layer2    = layer2_q;
		cmd.n_idx     = n_q;
		cmd.out_coast = coast_q;
		in_ready      = (state_q == S_IDLE);
		unique case (state_q)
			S_SC_RD, S_SC_GO, S_SC_WAIT: cmd.rd_addr = {8'b0, i_q[1:0]};
			S_B_RD, S_B_LD: cmd.rd_addr = (layer2_q ? b_b2 : b_b1) + {4'b0, n_q};
			default: cmd.rd_addr = w_ptr_q;
		endcase
		unique case (state_q)
			S_SC_GO: cmd.div_start = 1'b1;
			S_B_LD:  cmd.acc_load  = 1'b1;
			S_W_MUL: cmd.mul_en    = 1'b1;
			S_W_ACC: cmd.acc_en    = 1'b1;
			S_POST: begin
				cmd.h_wr      = !layer2_q;
				cmd.arg_upd   = layer2_q;
				cmd.arg_first = (n_q == '0);
			end
			S_DONE:  cmd.out_load  = slot_free;
			default: ;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			n_q      <= '0;
			w_ptr_q  <= '0;
			layer2_q <= 1'b0;
			coast_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					i_q      <= '0;
					n_q      <= '0;
					layer2_q <= 1'b0;
					w_ptr_q  <= 10'(OBS_COUNT);
					coast_q  <= !loaded_q;
				end
				S_SC_WAIT: if (st.div_done) i_q <= i_last ? 6'd0 : i_q + 6'd1;
				S_W_ACC: begin
					i_q     <= i_last ? 6'd0 : i_q + 6'd1;
					w_ptr_q <= w_ptr_q + 10'd1;
				end
				S_POST: begin
					if (n_last) begin
						n_q      <= '0;
						layer2_q <= 1'b1;
						w_ptr_q  <= b_w2;
					end else begin
						n_q <= n_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/mlp_policy_argmax_inference.sv =====
`timescale 1ns / 1ps
// Cart-pole policy: a write beat (operation 0) stores one Q16.16 word at param_index and
// returns nothing; an act beat (operation 1) scales the four observations, runs a tanh
// hidden layer and a linear output layer, and returns the first index of the largest logit,
// or 1 when model_loaded is clear. A write leaves the block ready for the next beat. Each
// scaling runs on a one-bit-per-cycle divider, and every multiply-accumulate uses the one
// shared multiplier fed by the single read port of the parameter memory. An unloaded act
// skips the computation. A new beat is taken once the previous act has placed its result
// in the output register, even while that result still waits.
module mlp_policy_argmax_inference (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic [9:0]         param_index,
	input  logic signed [31:0] param_value,
	input  logic signed [31:0] position,
	input  logic signed [31:0] velocity_obs,
	input  logic signed [31:0] angle,
	input  logic signed [31:0] angular_rate,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         action,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import mpa_pkg::*;

	mpa_cmd_t    cmd;
	mpa_status_t st;

	mpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	mpa_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.param_index  (param_index),
		.param_value  (param_value),
		.position     (position),
		.velocity_obs (velocity_obs),
		.angle        (angle),
		.angular_rate (angular_rate),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.action       (action)
	);

endmodule

// ===== rtl/mpa_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        operation,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action
);
	import mpa_pkg::*;

	// a stalled result beat holds
	`ASSERT_RST(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(action))
	// an act beat makes the block busy
	`ASSERT_RST(a_act_busy, clk, arst_n, in_valid && in_ready && operation == OP_ACT |=> !in_ready)
	// a write beat leaves the block ready
	`ASSERT_RST(a_wr_ready, clk, arst_n, in_valid && in_ready && operation == OP_WRITE |=> in_ready)
	// a new result arrives together with the return to ready
	`ASSERT_RST(a_res_ready, clk, arst_n, $rose(out_valid) |-> in_ready)

endmodule

bind mlp_policy_argmax_inference mpa_checker u_chk (.*);

// ===== tb/tb_mlp_policy_argmax_inference.sv =====
`timescale 1ns / 1ps
module tb_mlp_policy_argmax_inference;
	import mpa_pkg::*;

	localparam logic [1:0] CFG_SPARE   = 2'd3;
	localparam int         QUIET_LIMIT = 20000;
	localparam int         HOLD_CYCLES = 3000;
	// largest layout used: full hidden layer with a single output
	localparam int         LAYOUT_END  = OBS_COUNT + 6 * MAX_HIDDEN + 1;

	// Policy predictor: parameter memory copy, register copy, queue of expected actions
	class policy_scoreboard;
		bit [31:0]   param_mem [PARAM_DEPTH];
		bit          loaded;
		int unsigned hid_reg;
		int unsigned out_reg;
		longint      tanh_mag [TANH_LIMIT + 1];
		logic [2:0]  pending_actions [$];
		int          errors;
		int          acts;
		int          writes;

		function new();
			longint unsigned e;
			longint unsigned d;
			longint unsigned q;
			e = 64'h1_0000_0000;
			for (int n = 0; n <= TANH_LIMIT; n++) begin
				d = e + 64'h1_0000_0000;
				q = ((64'd1 << 49) + d / 2) / d;
				tanh_mag[n] = 65536 - longint'(q);
				e = e + (e >> 32) * EXP_STEP_FRAC + (((e & 64'hFFFF_FFFF) * EXP_STEP_FRAC) >> 32);
			end
			foreach (param_mem[i]) param_mem[i] = '0;
			loaded  = 0;
			hid_reg = 16;
			out_reg = 3;
		endfunction

		function void set_reg(logic [1:0] idx, logic [6:0] data);
			case (idx)
				CFG_MODEL_LOADED: loaded = data[0];
				CFG_HIDDEN_COUNT: hid_reg = data;
				CFG_OUTPUT_COUNT: out_reg = data[3:0];
				default: ;
			endcase
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint word(int unsigned addr);
			if (addr >= PARAM_DEPTH) return 0;
			return longint'($signed(param_mem[addr]));
		endfunction

		function longint squash(longint t);
			longint k;
			longint v;
			k = t >>> (FRAC_BITS - 5);
			if (k > TANH_LIMIT) k = TANH_LIMIT;
			if (k < -TANH_LIMIT) k = -TANH_LIMIT;
			v = tanh_mag[k < 0 ? -k : k];
			return k < 0 ? -v : v;
		endfunction

		function logic [2:0] greedy_action(bit [31:0] obs_raw [OBS_COUNT]);
			int unsigned h, o, b_b1, b_w2, b_b2, best;
			longint      obs [OBS_COUNT];
			longint      hid [MAX_HIDDEN];
			longint      acc, best_val, x, s;
			if (!loaded) return ACTION_COAST;
			h = hid_reg < 1 ? 1 : (hid_reg > MAX_HIDDEN ? MAX_HIDDEN : hid_reg);
			o = out_reg < 1 ? 1 : (out_reg > MAX_OUTPUTS ? MAX_OUTPUTS : out_reg);
			// scale observations, saturating on a zero scale
			for (int i = 0; i < OBS_COUNT; i++) begin
				x = longint'($signed(obs_raw[i]));
				s = word(i);
				if (s == 0) obs[i] = x > 0 ? 64'sd2147483647 : (x < 0 ? -64'sd2147483648 : 0);
				else obs[i] = sat32((x <<< FRAC_BITS) / s);
			end
			b_b1 = OBS_COUNT + h * OBS_COUNT;
			b_w2 = b_b1 + h;
			b_b2 = b_w2 + o * h;
			for (int n = 0; n < h; n++) begin
				acc = word(b_b1 + n);
				for (int i = 0; i < OBS_COUNT; i++)
					acc = sat32(acc + ((word(OBS_COUNT + n * OBS_COUNT + i) * obs[i]) >>> FRAC_BITS));
				hid[n] = squash(acc);
			end
			best = 0;
			best_val = 0;
			for (int n = 0; n < o; n++) begin
				acc = word(b_b2 + n);
				for (int i = 0; i < h; i++)
					acc = sat32(acc + ((word(b_w2 + n * h + i) * hid[i]) >>> FRAC_BITS));
				if (n == 0 || acc > best_val) begin
					best_val = acc;
					best = n;
				end
			end
			return best[2:0];
		endfunction

		function void note_input(bit op, bit [9:0] idx, bit [31:0] val, bit [31:0] obs_raw [OBS_COUNT]);
			if (op == OP_WRITE) begin
				param_mem[idx] = val;
				writes++;
			end else begin
				pending_actions.push_back(greedy_action(obs_raw));
				acts++;
			end
		endfunction

		function void check_action(logic [2:0] got);
			logic [2:0] want;
			if (pending_actions.size() == 0) begin
				$error("action: expected none, got %0d", got);
				errors++;
				return;
			end
			want = pending_actions.pop_front();
			if (got !== want) begin
				$error("action: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               operation;
	logic [9:0]         param_index;
	logic signed [31:0] param_value;
	logic signed [31:0] position;
	logic signed [31:0] velocity_obs;
	logic signed [31:0] angle;
	logic signed [31:0] angular_rate;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         action;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [6:0]         cfg_data;

	policy_scoreboard sb = new();
	int tx_idle_pct;
	int rx_stall_pct;
	bit hold_req;
	int quiet;

	mlp_policy_argmax_inference dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .param_index(param_index), .param_value(param_value),
		.position(position), .velocity_obs(velocity_obs), .angle(angle),
		.angular_rate(angular_rate),
		.out_valid(out_valid), .out_ready(out_ready), .action(action),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Drive ready low for stalls and for the long hold-off
	initial begin
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 0;
			end
			out_ready = ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// Check each result beat
	always @(posedge clk)
		if (arst_n && out_valid && out_ready) sb.check_action(action);

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
		else quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("[mlp_policy_argmax_inference] ERROR");
			$finish;
		end
	end

	task automatic send_beat(bit op, bit [9:0] idx, bit [31:0] val, bit [31:0] obs_raw [OBS_COUNT]);
		@(negedge clk);
		while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid = 0;
			@(negedge clk);
		end
		operation    = op;
		param_index  = idx;
		param_value  = val;
		position     = obs_raw[0];
		velocity_obs = obs_raw[1];
		angle        = obs_raw[2];
		angular_rate = obs_raw[3];
		in_valid     = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op, idx, val, obs_raw);
	endtask

	task automatic write_param(bit [9:0] idx, bit [31:0] val);
		bit [31:0] obs_raw [OBS_COUNT];
		foreach (obs_raw[i]) obs_raw[i] = $urandom;
		send_beat(OP_WRITE, idx, val, obs_raw);
	endtask

	task automatic act(bit [31:0] o0, bit [31:0] o1, bit [31:0] o2, bit [31:0] o3);
		bit [31:0] obs_raw [OBS_COUNT];
		obs_raw = '{o0, o1, o2, o3};
		send_beat(OP_ACT, 10'($urandom), $urandom, obs_raw);
	endtask

	// Wait for every expected action, then let trailing writes settle
	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (sb.pending_actions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] data);
		@(negedge clk);
		cfg_we    = 1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic bit [31:0] rand_word();
		case ($urandom_range(4))
			0: return $urandom_range(1 << 19) - (1 << 18);
			1: return $urandom;
			2: return 0;
			default: return $urandom_range(3 << 16, 1 << 14);
		endcase
	endfunction

	function automatic bit [31:0] rand_obs();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1 << 20) - (1 << 19);
			default: return $urandom_range(1 << 17) - (1 << 16);
		endcase
	endfunction

	task automatic random_mix(int count, int act_pct);
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < act_pct) act(rand_obs(), rand_obs(), rand_obs(), rand_obs());
			else if ($urandom_range(1)) write_param(10'($urandom_range(PARAM_DEPTH - 1)), rand_word());
			else write_param(10'($urandom_range(LAYOUT_END - 1)), rand_word());
		end
	endtask

	task automatic run_phase(logic [6:0] hid, logic [6:0] outs, int count, int act_pct);
		write_reg(CFG_HIDDEN_COUNT, hid);
		write_reg(CFG_OUTPUT_COUNT, outs);
		for (int m = 0; m < 4; m++) begin
			tx_idle_pct  = (m == 1) ? 77 : (m == 3 ? 14 : 0);
			rx_stall_pct = (m == 2) ? 77 : (m == 3 ? 14 : 0);
			random_mix(count, act_pct);
			drain();
		end
	endtask

	initial begin
		arst_n       = 0;
		in_valid     = 0;
		operation    = OP_WRITE;
		param_index  = '0;
		param_value  = '0;
		position     = '0;
		velocity_obs = '0;
		angle        = '0;
		angular_rate = '0;
		cfg_we       = 0;
		cfg_index    = CFG_MODEL_LOADED;
		cfg_data     = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = 0;
		quiet        = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// unloaded model answers coast
		act(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF);
		act(0, 0, 0, 0);
		// load every word the largest layout can touch
		for (int a = 0; a < LAYOUT_END; a++)
			write_param(10'(a), a < OBS_COUNT ? 32'h0001_0000 : rand_word());
		drain();
		write_reg(CFG_SPARE, 7'h7F);
		write_reg(CFG_MODEL_LOADED, 1);
		write_reg(CFG_HIDDEN_COUNT, 4);
		write_reg(CFG_OUTPUT_COUNT, 3);

		// observation extremes, zero scale, extreme scales and weights
		act(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF);
		act(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
		write_param(0, 0);
		write_param(1, 32'hFFFF_FFFF);
		write_param(2, 32'h8000_0000);
		write_param(3, 32'h7FFF_FFFF);
		act(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		act(32'h8000_0000, 1, 32'h7FFF_FFFF, 0);
		act(0, 0, 0, 0);
		write_param(4, 32'h7FFF_FFFF);
		write_param(5, 32'h8000_0000);
		write_param(10'(OBS_COUNT + 4 * OBS_COUNT), 32'h7FFF_FFFF);
		act(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		act(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		for (int i = 0; i < OBS_COUNT; i++) write_param(10'(i), 32'h0001_0000);
		write_param(10'(PARAM_DEPTH - 1), 32'h5555_AAAA);
		drain();

		// random phases over several layer sizes, extremes and clamped counts among them
		run_phase(16, 3, 30, 35);
		run_phase(0, 0, 20, 40);
		run_phase(1, 1, 15, 40);
		run_phase(127, 1, 4, 50);
		run_phase(64, 1, 4, 50);
		run_phase(5, 7, 20, 35);
		run_phase(2, 15, 20, 35);

		// long receiver hold-off while acts keep coming
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_req     = 1;
		for (int n = 0; n < 6; n++) act(rand_obs(), rand_obs(), rand_obs(), rand_obs());
		drain();

		write_reg(CFG_MODEL_LOADED, 0);
		run_phase(16, 3, 8, 60);
		write_reg(CFG_MODEL_LOADED, 1);
		run_phase(3, 2, 15, 40);

		repeat (50) @(posedge clk);
		if (sb.pending_actions.size() != 0) begin
			$error("action: %0d expected results never arrived", sb.pending_actions.size());
			sb.errors++;
		end
		$display("Run covered %0d act beats and %0d parameter writes across", sb.acts, sb.writes);
		$display("hidden sizes 1..64, output sizes 1..8, loaded and unloaded, with stalls.");
		if (sb.errors == 0) $display("[mlp_policy_argmax_inference] OK");
		else $display("[mlp_policy_argmax_inference] ERROR");
		$finish;
	end
endmodule
